FILE: rtl/slhr_pkg.sv
// shared types, constants and helper functions for the slewed hue ring ripple block
package slhr_pkg;

   localparam logic [31:0] HOLD_TIME_RESET   = 32'd1000;
   localparam logic [7:0]  PIXEL_COUNT_RESET = 8'd1;
   localparam logic [7:0]  HUE_STEP          = 8'd8;
   localparam logic [7:0]  VALUE_STEP        = 8'd12;
   localparam logic [7:0]  FULL_SCALE        = 8'd255;
   localparam logic [7:0]  RIPPLE_SPAN       = 8'd16;
   localparam int          RING_COUNT        = 4;
   localparam int          MAX_RINGS         = 4;
   localparam int          RING_W            = 2;
   localparam logic [RING_W-1:0] RING_LAST =
      (RING_COUNT > MAX_RINGS) ? RING_W'(MAX_RINGS - 1) :
      (RING_COUNT < 1)         ? RING_W'(0) : RING_W'(RING_COUNT - 1);

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HOLD_TIME   = 1'b0,
      CSR_PIXEL_COUNT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      SEG_RED_UP    = 3'd0,
      SEG_RED_DOWN  = 3'd1,
      SEG_BLUE_UP   = 3'd2,
      SEG_GREEN_DN  = 3'd3,
      SEG_RED_RISE  = 3'd4,
      SEG_BLUE_DN   = 3'd5
   } seg_type;

   typedef struct packed {
      seg_type    seg;
      logic [7:0] rem;
   } hue_split_type;

   // six segments of 43 hue steps (the last of 41), remainder scaled by six
   function automatic hue_split_type hue_split(input logic [7:0] hue);
      hue_split_type res;
      logic [7:0]    base;
      logic [7:0]    d;
      priority if (hue >= 8'd215) begin
         res.seg = SEG_BLUE_DN;  base = 8'd215;
      end else if (hue >= 8'd172) begin
         res.seg = SEG_RED_RISE; base = 8'd172;
      end else if (hue >= 8'd129) begin
         res.seg = SEG_GREEN_DN; base = 8'd129;
      end else if (hue >= 8'd86) begin
         res.seg = SEG_BLUE_UP;  base = 8'd86;
      end else if (hue >= 8'd43) begin
         res.seg = SEG_RED_DOWN; base = 8'd43;
      end else begin
         res.seg = SEG_RED_UP;   base = 8'd0;
      end
      d = hue - base;
      res.rem = 8'({d, 2'b00}) + 8'({d, 1'b0});
      return res;
   endfunction

   // floor of x / 255 for x up to 255 * 255
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [8:0] s;
      s = {1'b0, x[15:8]} + {1'b0, x[7:0]};
      return x[15:8] + ((s >= 9'd255) ? 8'd1 : 8'd0);
   endfunction

   function automatic logic [7:0] slew(input logic [7:0] cur, input logic [7:0] target,
                                       input logic [7:0] step);
      logic [7:0] res;
      if (target > cur) begin
         res = ((target - cur) > step) ? cur + step : target;
      end else begin
         res = ((cur - target) > step) ? cur - step : target;
      end
      return res;
   endfunction

endpackage

FILE: rtl/slhr_req_if.sv
// show frame request channel
interface slhr_req_if;
   logic        valid;
   logic        ready;
   logic        frame_present;
   logic        frame_received;
   logic [31:0] now_ms;
   logic [31:0] rx_ms;
   logic [7:0]  frame_hue;
   logic [7:0]  frame_val;
   logic [15:0] frame_phase;

   modport source (output valid, frame_present, frame_received, now_ms, rx_ms,
                   frame_hue, frame_val, frame_phase, input ready);
   modport sink   (input valid, frame_present, frame_received, now_ms, rx_ms,
                   frame_hue, frame_val, frame_phase, output ready);
endinterface

FILE: rtl/slhr_rsp_if.sv
// colour response channel
interface slhr_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  ring_index;
   logic [7:0]  red;
   logic [7:0]  green;
   logic [7:0]  blue;
   logic [7:0]  intensity;
   logic [15:0] phase_out;
   logic        last;

   modport source (output valid, ring_index, red, green, blue, intensity, phase_out,
                   last, input ready);
   modport sink   (input valid, ring_index, red, green, blue, intensity, phase_out,
                   last, output ready);
endinterface

FILE: rtl/slewed_hue_ring_ripple.sv
// top level: slewed hue and value with per ring ripple, one shared multiplier
//
//   channel  | dir | transfer when        | payload
//   req_chan | in  | valid && ready       | frame fields, times, phase
//   rsp_chan | out | valid && ready       | ring, rgb, intensity, phase, last
//   csr      | in  | csr_we               | hold time, pixel count
//
// a request is taken in idle, then the slew state updates hue and value, then
// each result passes through the shared multiplier steps ripple, q, t and load
// a stalled response holds the sequencer before loading the next result only
// reset is synchronous, clears state and the response valid and loads the default settings
module slewed_hue_ring_ripple (
   input  logic clock,
   input  logic reset,
   slhr_req_if.sink   req_chan,
   slhr_rsp_if.source rsp_chan,
   input  logic                                   csr_we,
   input  logic [slhr_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [slhr_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import slhr_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SLEW,
      ST_MULV,
      ST_MULQ,
      ST_MULT,
      ST_EMIT
   } state_type;

   state_type       state_ff;
   logic [31:0]     hold_time_ff;
   logic [7:0]      pixel_count_ff;
   logic [7:0]      hue_now_ff;
   logic [7:0]      value_now_ff;

   logic            received_ff;
   logic [31:0]     age_ff;
   logic [7:0]      frame_hue_ff;
   logic [7:0]      frame_val_ff;
   logic [15:0]     phase_ff;
   logic [RING_W-1:0] ring_ff;
   logic [7:0]      v_ff;
   logic [7:0]      q_ff;

   logic            rsp_valid_ff;
   logic [1:0]      ring_index_ff;
   logic [7:0]      red_ff;
   logic [7:0]      green_ff;
   logic [7:0]      blue_ff;
   logic [7:0]      intensity_ff;
   logic [15:0]     phase_out_ff;
   logic            last_ff;

   logic [7:0]      op_a;
   logic [7:0]      op_b;
   logic [15:0]     product;
   logic            point_mode;
   logic [RING_W-1:0] ring_last;
   logic [3:0]      ring_phase;
   logic [4:0]      ripple;
   hue_split_type   split;
   logic [7:0]      t_val;
   logic [7:0]      tval;
   logic [7:0]      thue;
   logic            slot_free;
   logic [7:0]      r_sel;
   logic [7:0]      g_sel;
   logic [7:0]      b_sel;

   assign point_mode = (pixel_count_ff == 8'd1);
   assign ring_last  = point_mode ? RING_W'(0) : RING_LAST;
   assign ring_phase = point_mode ? 4'd0 : (phase_ff[3:0] + 4'({ring_ff, 2'b00}));
   assign ripple     = 5'(RIPPLE_SPAN) - {1'b0, ring_phase};
   assign split      = hue_split(hue_now_ff);
   assign t_val      = div255(product);
   assign slot_free  = !rsp_valid_ff || rsp_chan.ready;

   assign tval = !received_ff ? 8'd0 :
                 (age_ff <= hold_time_ff) ? frame_val_ff : {1'b0, frame_val_ff[7:1]};
   assign thue = received_ff ? frame_hue_ff : hue_now_ff;

   always_comb begin
      unique case (state_ff)
         ST_MULV: begin
            op_a = value_now_ff;
            op_b = 8'(ripple);
         end
         ST_MULQ: begin
            op_a = product[11:4];
            op_b = FULL_SCALE - split.rem;
         end
         ST_MULT, ST_EMIT: begin
            op_a = v_ff;
            op_b = split.rem;
         end
         default: begin
            op_a = 8'd0;
            op_b = 8'd0;
         end
      endcase
   end

   always_comb begin
      unique case (split.seg)
         SEG_RED_UP:   begin r_sel = v_ff;  g_sel = t_val; b_sel = 8'd0;  end
         SEG_RED_DOWN: begin r_sel = q_ff;  g_sel = v_ff;  b_sel = 8'd0;  end
         SEG_BLUE_UP:  begin r_sel = 8'd0;  g_sel = v_ff;  b_sel = t_val; end
         SEG_GREEN_DN: begin r_sel = 8'd0;  g_sel = q_ff;  b_sel = v_ff;  end
         SEG_RED_RISE: begin r_sel = t_val; g_sel = 8'd0;  b_sel = v_ff;  end
         default:      begin r_sel = v_ff;  g_sel = 8'd0;  b_sel = q_ff;  end
      endcase
   end

   slhr_mul u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .product (product)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         hold_time_ff   <= HOLD_TIME_RESET;
         pixel_count_ff <= PIXEL_COUNT_RESET;
         hue_now_ff     <= 8'd0;
         value_now_ff   <= 8'd0;
         rsp_valid_ff   <= 1'b0;
         ring_ff        <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_HOLD_TIME:   hold_time_ff   <= csr_wdata;
               CSR_PIXEL_COUNT: pixel_count_ff <= csr_wdata[7:0];
               default: ;
            endcase
         end

         if (rsp_valid_ff && rsp_chan.ready && (state_ff != ST_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_chan.valid) begin
                  received_ff  <= req_chan.frame_present & req_chan.frame_received;
                  age_ff       <= req_chan.now_ms - req_chan.rx_ms;
                  frame_hue_ff <= req_chan.frame_hue;
                  frame_val_ff <= req_chan.frame_val;
                  phase_ff     <= req_chan.frame_present ? req_chan.frame_phase : 16'd0;
                  state_ff     <= ST_SLEW;
               end
            end
            ST_SLEW: begin
               hue_now_ff   <= slew(hue_now_ff, thue, HUE_STEP);
               value_now_ff <= slew(value_now_ff, tval, VALUE_STEP);
               ring_ff      <= '0;
               state_ff     <= ST_MULV;
            end
            ST_MULV: begin
               state_ff <= ST_MULQ;
            end
            ST_MULQ: begin
               v_ff     <= product[11:4];
               state_ff <= ST_MULT;
            end
            ST_MULT: begin
               q_ff     <= div255(product);
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (slot_free) begin
                  rsp_valid_ff  <= 1'b1;
                  ring_index_ff <= 2'(ring_ff);
                  red_ff        <= r_sel;
                  green_ff      <= g_sel;
                  blue_ff       <= b_sel;
                  intensity_ff  <= value_now_ff;
                  phase_out_ff  <= phase_ff;
                  last_ff       <= (ring_ff == ring_last);
                  if (ring_ff == ring_last) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     ring_ff  <= ring_ff + RING_W'(1);
                     state_ff <= ST_MULV;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.ring_index = ring_index_ff;
   assign rsp_chan.red        = red_ff;
   assign rsp_chan.green      = green_ff;
   assign rsp_chan.blue       = blue_ff;
   assign rsp_chan.intensity  = intensity_ff;
   assign rsp_chan.phase_out  = phase_out_ff;
   assign rsp_chan.last       = last_ff;
endmodule

FILE: rtl/slhr_mul.sv
// shared 8 by 8 multiplier with registered product
module slhr_mul (
   input  logic        clock,
   input  logic [7:0]  op_a,
   input  logic [7:0]  op_b,
   output logic [15:0] product
);
   logic [15:0] prod_ff;
   logic [15:0] prod_in;

   assign prod_in = 16'(op_a) * 16'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign product = prod_ff;
endmodule
